>>> rtl/core/tsli_pkg.sv
// ----------------------------------------------------------------------------
// tsli_pkg
// Shared widths, codes, table entry and interpolator handshake types, and the
// 32-bit saturation used by the table search linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int WL_W      = 32;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 9;
    localparam int TOL_W     = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOL_W-1:0] END_TOL_RESET = 20'd1049;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TOLERANCE = 1'b1;

    typedef struct packed {
        logic        [WL_W-1:0]  wl;
        logic signed [VAL_W-1:0] idx;
        logic signed [VAL_W-1:0] ext;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic        [31:0] dx;
        logic        [31:0] dw;
        logic signed [32:0] a_r;
        logic signed [32:0] dy_r;
        logic signed [32:0] a_i;
        logic signed [32:0] dy_i;
    } lerp_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] res_r;
        logic signed [31:0] res_i;
    } lerp_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            r = v[31:0];
        end
        else if (v[34]) begin
            r = {1'b1, {31{1'b0}}};
        end
        else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tsli_table_mem.sv
// ----------------------------------------------------------------------------
// tsli_table_mem
// Single write port, single read port table memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsli_table_mem #(
    parameter int TABLE_DEPTH = tsli_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  tsli_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output tsli_pkg::entry_t     rd_data
);
    import tsli_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/tsli_lerp_unit.sv
// ----------------------------------------------------------------------------
// tsli_lerp_unit
// Two-lane interpolator: a + trunc(dx * dy / dw) for the real and imaginary
// parts, using a split 32x17 multiply and a restoring one-bit-per-cycle divide.
// ----------------------------------------------------------------------------
`default_nettype none

module tsli_lerp_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsli_pkg::lerp_req_t   req,
    output tsli_pkg::lerp_rsp_t   rsp
);
    import tsli_pkg::*;

    localparam int LANES     = 2;
    localparam int MUL_STEPS = 3;
    localparam int DIV_STEPS = 33;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_FIN  = 2'd3;

    logic [1:0]        ustate_reg, ustate_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;

    logic [31:0]        dx_reg, dx_next;
    logic [31:0]        dw_reg, dw_next;
    logic [32:0]        mag_reg  [LANES];
    logic [32:0]        mag_next [LANES];
    logic               neg_reg  [LANES];
    logic               neg_next [LANES];
    logic signed [32:0] a_reg    [LANES];
    logic signed [32:0] a_next   [LANES];
    logic [48:0]        prod_reg [LANES];
    logic [48:0]        prod_next[LANES];
    logic [47:0]        lo_reg   [LANES];
    logic [47:0]        lo_next  [LANES];
    logic [31:0]        rem_reg  [LANES];
    logic [31:0]        rem_next [LANES];
    logic [32:0]        sh_reg   [LANES];
    logic [32:0]        sh_next  [LANES];
    logic [32:0]        quo_reg  [LANES];
    logic [32:0]        quo_next [LANES];
    logic signed [31:0] res_reg  [LANES];
    logic signed [31:0] res_next [LANES];

    logic [16:0]        mul_b    [LANES];
    logic [48:0]        prod     [LANES];
    logic [64:0]        sum      [LANES];
    logic [32:0]        trial    [LANES];
    logic [32:0]        diff     [LANES];
    logic               ge       [LANES];
    logic [34:0]        fin_val  [LANES];
    logic signed [32:0] dy_in    [LANES];
    logic signed [32:0] a_in     [LANES];

    always_comb
    begin
        dy_in[0] = req.dy_r;
        dy_in[1] = req.dy_i;
        a_in[0]  = req.a_r;
        a_in[1]  = req.a_i;
        for (int l = 0; l < LANES; l++)
        begin
            mul_b[l]   = (step_reg == '0) ? {1'b0, mag_reg[l][15:0]} : mag_reg[l][32:16];
            prod[l]    = {17'b0, dx_reg} * {32'b0, mul_b[l]};
            sum[l]     = {17'b0, lo_reg[l]} + {prod_reg[l], 16'b0};
            trial[l]   = {rem_reg[l], sh_reg[l][32]};
            diff[l]    = trial[l] - {1'b0, dw_reg};
            ge[l]      = (trial[l] >= {1'b0, dw_reg});
            fin_val[l] = neg_reg[l] ? ({{2{a_reg[l][32]}}, a_reg[l]} - {2'b0, quo_reg[l]})
                                    : ({{2{a_reg[l][32]}}, a_reg[l]} + {2'b0, quo_reg[l]});
        end
    end

    always_comb
    begin
        ustate_next = ustate_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        dx_next     = dx_reg;
        dw_next     = dw_reg;
        for (int l = 0; l < LANES; l++)
        begin
            mag_next[l]  = mag_reg[l];
            neg_next[l]  = neg_reg[l];
            a_next[l]    = a_reg[l];
            prod_next[l] = prod_reg[l];
            lo_next[l]   = lo_reg[l];
            rem_next[l]  = rem_reg[l];
            sh_next[l]   = sh_reg[l];
            quo_next[l]  = quo_reg[l];
            res_next[l]  = res_reg[l];
        end

        case (ustate_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    dx_next   = req.dx;
                    dw_next   = req.dw;
                    step_next = '0;
                    for (int l = 0; l < LANES; l++)
                    begin
                        neg_next[l] = dy_in[l][32];
                        mag_next[l] = dy_in[l][32] ? (33'd0 - dy_in[l]) : dy_in[l];
                        a_next[l]   = a_in[l];
                    end
                    ustate_next = U_MUL;
                end
            end
            U_MUL:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    prod_next[l] = prod[l];
                    if (step_reg == STEP_W'(1))
                    begin
                        lo_next[l] = prod_reg[l][47:0];
                    end
                    if (step_reg == STEP_W'(MUL_STEPS - 1))
                    begin
                        rem_next[l] = sum[l][64:33];
                        sh_next[l]  = sum[l][32:0];
                    end
                end
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    step_next   = '0;
                    ustate_next = U_DIV;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            U_DIV:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_next[l] = ge[l] ? diff[l][31:0] : trial[l][31:0];
                    sh_next[l]  = {sh_reg[l][31:0], 1'b0};
                    quo_next[l] = {quo_reg[l][31:0], ge[l]};
                end
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    ustate_next = U_FIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            U_FIN:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    res_next[l] = sat32($signed(fin_val[l]));
                end
                done_next   = 1'b1;
                ustate_next = U_IDLE;
            end
            default:
            begin
                ustate_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ustate_reg <= U_IDLE;
            step_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ustate_reg <= ustate_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dw_reg <= dw_next;
        for (int l = 0; l < LANES; l++)
        begin
            mag_reg[l]  <= mag_next[l];
            neg_reg[l]  <= neg_next[l];
            a_reg[l]    <= a_next[l];
            prod_reg[l] <= prod_next[l];
            lo_reg[l]   <= lo_next[l];
            rem_reg[l]  <= rem_next[l];
            sh_reg[l]   <= sh_next[l];
            quo_reg[l]  <= quo_next[l];
            res_reg[l]  <= res_next[l];
        end
    end

    always_comb
    begin
        rsp.done  = done_reg;
        rsp.res_r = res_reg[0];
        rsp.res_i = res_reg[1];
    end

endmodule

`default_nettype wire

>>> rtl/core/tsli_query_ctrl.sv
// ----------------------------------------------------------------------------
// tsli_query_ctrl
// Query sequencer: binary search over the table memory, end-of-table
// tolerance check, neighbor fetch for interpolation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsli_query_ctrl #(
    parameter int TABLE_DEPTH = tsli_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH),
    parameter int POS_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          op,
    input  logic [tsli_pkg::WL_W-1:0]     wavelength,
    input  logic [tsli_pkg::CNT_W-1:0]    entry_count,
    input  logic [tsli_pkg::TOL_W-1:0]    end_tolerance,
    output logic                          in_stall,
    output logic                          rd_en,
    output logic [ADDR_W-1:0]             rd_addr,
    input  tsli_pkg::entry_t              rd_data,
    output tsli_pkg::lerp_req_t           lerp_req,
    input  tsli_pkg::lerp_rsp_t           lerp_rsp,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic signed [tsli_pkg::VAL_W-1:0] result_real,
    output logic signed [tsli_pkg::VAL_W-1:0] result_imag,
    output logic                          out_of_range
);
    import tsli_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_END   = 3'd3;
    localparam logic [2:0] S_LEFT  = 3'd4;
    localparam logic [2:0] S_RIGHT = 3'd5;
    localparam logic [2:0] S_LERP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [WL_W-1:0]        wl_reg, wl_next;
    logic [POS_W-1:0]       n_reg, n_next;
    logic [POS_W-1:0]       lo_reg, lo_next;
    logic [POS_W-1:0]       hi_reg, hi_next;
    entry_t                 left_reg, left_next;
    logic signed [VAL_W-1:0] res_r_reg, res_r_next;
    logic signed [VAL_W-1:0] res_i_reg, res_i_next;
    logic                   res_flag_reg, res_flag_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_real_reg, out_real_next;
    logic signed [VAL_W-1:0] out_imag_reg, out_imag_next;
    logic                   out_flag_reg, out_flag_next;

    logic [POS_W-1:0]       n_cfg;
    logic [POS_W-1:0]       mid;
    logic [POS_W-1:0]       end_pos;
    logic [POS_W-1:0]       lo_m1;
    logic                   at_end;
    logic [WL_W-1:0]        end_dist;
    logic                   in_tol;
    logic signed [32:0]     end_neg_ext;
    logic signed [32:0]     r1_x;
    logic signed [32:0]     r2_x;
    logic signed [32:0]     k1_x;
    logic signed [32:0]     k2_x;
    logic                   out_load;

    assign n_cfg = ({{(32 - CNT_W){1'b0}}, entry_count} > 32'(TABLE_DEPTH))
                   ? POS_W'(TABLE_DEPTH) : POS_W'(entry_count);
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign at_end  = (lo_reg == '0) || (lo_reg == n_reg);
    assign end_pos = (lo_reg == n_reg) ? (n_reg - POS_W'(1)) : '0;
    assign lo_m1   = lo_reg - POS_W'(1);

    assign end_dist = (rd_data.wl > wl_reg) ? (rd_data.wl - wl_reg) : (wl_reg - rd_data.wl);
    assign in_tol   = (end_dist < {{(WL_W - TOL_W){1'b0}}, end_tolerance});
    assign end_neg_ext = 33'sd0 - {rd_data.ext[VAL_W-1], rd_data.ext};

    assign r1_x = {left_reg.idx[VAL_W-1], left_reg.idx};
    assign r2_x = {rd_data.idx[VAL_W-1], rd_data.idx};
    assign k1_x = {left_reg.ext[VAL_W-1], left_reg.ext};
    assign k2_x = {rd_data.ext[VAL_W-1], rd_data.ext};

    always_comb
    begin
        lerp_req.start = (state_reg == S_RIGHT);
        lerp_req.dx    = wl_reg - left_reg.wl;
        lerp_req.dw    = rd_data.wl - left_reg.wl;
        lerp_req.a_r   = r1_x;
        lerp_req.dy_r  = r2_x - r1_x;
        lerp_req.a_i   = 33'sd0 - k1_x;
        lerp_req.dy_i  = k1_x - k2_x;
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next    = state_reg;
        wl_next       = wl_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        left_next     = left_reg;
        res_r_next    = res_r_reg;
        res_i_next    = res_i_reg;
        res_flag_next = res_flag_reg;
        rd_en         = 1'b0;
        rd_addr       = mid[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && op == OP_QUERY)
                begin
                    wl_next       = wavelength;
                    n_next        = n_cfg;
                    lo_next       = '0;
                    hi_next       = n_cfg;
                    res_r_next    = '0;
                    res_i_next    = '0;
                    res_flag_next = 1'b1;
                    state_next    = (n_cfg == '0) ? S_DONE : S_SRCH;
                end
            end
            S_SRCH:
            begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid[ADDR_W-1:0];
                    state_next = S_CMP;
                end
                else if (at_end)
                begin
                    rd_addr    = end_pos[ADDR_W-1:0];
                    state_next = S_END;
                end
                else
                begin
                    rd_addr    = lo_m1[ADDR_W-1:0];
                    state_next = S_LEFT;
                end
            end
            S_CMP:
            begin
                if (rd_data.wl < wl_reg)
                begin
                    lo_next = mid + POS_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH;
            end
            S_END:
            begin
                if (in_tol)
                begin
                    res_r_next    = rd_data.idx;
                    res_i_next    = sat32({{2{end_neg_ext[32]}}, end_neg_ext});
                    res_flag_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_LEFT:
            begin
                left_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = lo_reg[ADDR_W-1:0];
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                state_next = S_LERP;
            end
            S_LERP:
            begin
                if (lerp_rsp.done)
                begin
                    res_r_next    = lerp_rsp.res_r;
                    res_i_next    = lerp_rsp.res_i;
                    res_flag_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && out_stall);
        out_real_next  = out_load ? res_r_reg : out_real_reg;
        out_imag_next  = out_load ? res_i_reg : out_imag_reg;
        out_flag_next  = out_load ? res_flag_reg : out_flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wl_reg       <= wl_next;
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        left_reg     <= left_next;
        res_r_reg    <= res_r_next;
        res_i_reg    <= res_i_next;
        res_flag_reg <= res_flag_next;
        out_real_reg <= out_real_next;
        out_imag_reg <= out_imag_next;
        out_flag_reg <= out_flag_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_real  = out_real_reg;
    assign result_imag  = out_imag_reg;
    assign out_of_range = out_flag_reg;

endmodule

`default_nettype wire

>>> rtl/core/table_search_linear_interpolator.sv
// Write item: one transfer per cycle unless stalled; stored when taken; no result.
// Query: p search probes (at most 9 for 256 entries), then a tolerance check at the
//   table ends, or neighbor fetch and interpolation inside (none for an empty table).
// The input stays stalled until the result enters the output register;
//   the divider produces one quotient bit per cycle, 33 bits per quotient.
// Reset clears control and entry count, presets end tolerance; memory is not reset.
// ----------------------------------------------------------------------------
// table_search_linear_interpolator
// Sorted table of wavelength, index and extinction entries with binary search
// and linear interpolation of the real index and negated extinction.
// ----------------------------------------------------------------------------
`default_nettype none

module table_search_linear_interpolator #(
    parameter int TABLE_DEPTH = tsli_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tsli_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsli_pkg::TOL_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [7:0]                        entry_index,
    input  logic [tsli_pkg::WL_W-1:0]         wavelength,
    input  logic signed [tsli_pkg::VAL_W-1:0] index_value,
    input  logic signed [tsli_pkg::VAL_W-1:0] extinction_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [tsli_pkg::VAL_W-1:0] result_real,
    output logic signed [tsli_pkg::VAL_W-1:0] result_imag,
    output logic                              out_of_range
);
    import tsli_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int POS_W  = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [TOL_W-1:0] end_tolerance_reg, end_tolerance_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;
    lerp_req_t         lerp_req;
    lerp_rsp_t         lerp_rsp;

    always_comb
    begin
        entry_count_next   = entry_count_reg;
        end_tolerance_next = end_tolerance_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT:   entry_count_next   = cfg_data[CNT_W-1:0];
                CFG_END_TOLERANCE: end_tolerance_next = cfg_data;
                default:           entry_count_next   = entry_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg   <= '0;
            end_tolerance_reg <= END_TOL_RESET;
        end
        else
        begin
            entry_count_reg   <= entry_count_next;
            end_tolerance_reg <= end_tolerance_next;
        end
    end

    // drop writes to slots beyond the table
    assign wr_en = in_valid && !in_stall && (op == OP_WRITE)
                   && ({24'b0, entry_index} < 32'(TABLE_DEPTH));
    assign wr_addr = ADDR_W'(entry_index);

    always_comb
    begin
        wr_data.wl  = wavelength;
        wr_data.idx = index_value;
        wr_data.ext = extinction_value;
    end

    tsli_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_table_mem (
        .clk     (clk),
        .we      (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsli_query_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W),
        .POS_W       (POS_W)
    ) u_query_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .op            (op),
        .wavelength    (wavelength),
        .entry_count   (entry_count_reg),
        .end_tolerance (end_tolerance_reg),
        .in_stall      (in_stall),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .lerp_req      (lerp_req),
        .lerp_rsp      (lerp_rsp),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .result_real   (result_real),
        .result_imag   (result_imag),
        .out_of_range  (out_of_range)
    );

    tsli_lerp_unit u_lerp_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .rsp   (lerp_rsp)
    );

endmodule

`default_nettype wire

>>> rtl/core/tsli_checker.sv
// ----------------------------------------------------------------------------
// tsli_port_checks
// Port-level checks of the table search linear interpolator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tsli_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic [0:0]  cfg_index,
    input logic [19:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic        op,
    input logic [7:0]  entry_index,
    input logic [31:0] wavelength,
    input logic [31:0] index_value,
    input logic [31:0] extinction_value,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_real,
    input logic [31:0] result_imag,
    input logic        out_of_range
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_real)
            && $stable(result_imag) && $stable(out_of_range))
        else $error("stalled result changed");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> result_real == 32'd0 && result_imag == 32'd0)
        else $error("flagged result not zero");

    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !op |=> !in_stall)
        else $error("write transfer left the input stalled");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op |=> in_stall)
        else $error("query transfer did not stall the input");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a query in progress");

endmodule

bind table_search_linear_interpolator tsli_port_checks u_tsli_port_checks (.*);

`default_nettype wire
